// ===== rtl/core/point_in_triangle_test_macros.svh =====
`ifndef POINT_IN_TRIANGLE_TEST_MACROS_SVH
`define POINT_IN_TRIANGLE_TEST_MACROS_SVH
// Clocked check, masked while reset is asserted.
`define PIT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check, live through reset.
`define PIT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== rtl/core/pit_pkg.sv =====
// ----------------------------------------------------------------------------
// pit_pkg
// Widths, stage counts and types shared by the point-in-triangle pipeline.
// ----------------------------------------------------------------------------
package pit_pkg;

  localparam int COORD_W   = 32;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int CROSS_W   = PROD_W + 1;
  localparam int MAG_W     = PROD_W;
  localparam int RED_W     = 31;
  localparam int SQ_W      = 2 * RED_W;
  localparam int SUM_W     = SQ_W + 2;
  localparam int NORM_W    = SUM_W / 2;
  localparam int REM_W     = NORM_W + 2;
  localparam int FRAC_W    = 30;
  localparam int Q_W       = FRAC_W + 1;
  localparam int UNIT_W    = Q_W + 1;
  localparam int UDIF_W    = UNIT_W + 1;
  localparam int TOL_W     = 31;
  localparam int TOL_RESET = 1074;

  // normalize shift search: binary steps, two per stage
  localparam int SHIFT_STEPS     = 6;
  localparam int STEPS_PER_STAGE = 2;
  localparam int SHIFT_STAGES    = SHIFT_STEPS / STEPS_PER_STAGE;
  localparam int SHIFT_AMT [SHIFT_STEPS] = '{32, 16, 8, 4, 2, 1};

  localparam int LAT_CROSS   = 4;
  localparam int LAT_SCALE   = SHIFT_STAGES + 2;
  localparam int SQRT_STAGES = NORM_W;
  localparam int DIV_STEPS   = Q_W;
  localparam int LAT_DIV     = DIV_STEPS + 1;
  localparam int LAT_CMP     = 2;
  localparam int LAT_TOTAL   = LAT_CROSS + LAT_SCALE + SQRT_STAGES + LAT_DIV + LAT_CMP;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [MAG_W-1:0]          mag_t;
  typedef logic [RED_W-1:0]          red_t;
  typedef logic [SUM_W-1:0]          sum_t;
  typedef logic [NORM_W-1:0]         norm_t;
  typedef logic signed [UNIT_W-1:0]  unit_t;

  // per-edge sideband that rides along the square root
  typedef struct packed {
    logic [2:0]       neg;
    logic             nz;
    logic [2:0][RED_W-1:0] m;
  } side_t;

endpackage

// ===== rtl/core/pit_cross.sv =====
// ----------------------------------------------------------------------------
// pit_cross
// Exact edge cross product, four stages, result as sign and magnitude.
// ----------------------------------------------------------------------------
module pit_cross (
  input  logic            clk,
  input  logic            en,
  input  pit_pkg::coord_t s_i [3],
  input  pit_pkg::coord_t e_i [3],
  input  pit_pkg::coord_t p_i [3],
  output pit_pkg::mag_t   mag_o [3],
  output logic [2:0]      neg_o
);

  logic signed [pit_pkg::DIFF_W-1:0]  ed_r [3];
  logic signed [pit_pkg::DIFF_W-1:0]  pd_r [3];
  logic signed [pit_pkg::PROD_W-1:0]  prod_r [6];
  logic signed [pit_pkg::CROSS_W-1:0] cr_r [3];
  pit_pkg::mag_t                      mag_r [3];
  logic [2:0]                         neg_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ed_r[i] <= {e_i[i][pit_pkg::COORD_W-1], e_i[i]} - {s_i[i][pit_pkg::COORD_W-1], s_i[i]};
        pd_r[i] <= {p_i[i][pit_pkg::COORD_W-1], p_i[i]} - {s_i[i][pit_pkg::COORD_W-1], s_i[i]};
      end
      prod_r[0] <= ed_r[1] * pd_r[2];
      prod_r[1] <= ed_r[2] * pd_r[1];
      prod_r[2] <= ed_r[2] * pd_r[0];
      prod_r[3] <= ed_r[0] * pd_r[2];
      prod_r[4] <= ed_r[0] * pd_r[1];
      prod_r[5] <= ed_r[1] * pd_r[0];
      for (int i = 0; i < 3; i++) begin
        cr_r[i] <= {prod_r[2*i][pit_pkg::PROD_W-1], prod_r[2*i]}
                 - {prod_r[2*i+1][pit_pkg::PROD_W-1], prod_r[2*i+1]};
        neg_r[i] <= cr_r[i][pit_pkg::CROSS_W-1];
        mag_r[i] <= cr_r[i][pit_pkg::CROSS_W-1] ? pit_pkg::MAG_W'(-cr_r[i])
                                                : pit_pkg::MAG_W'(cr_r[i]);
      end
    end
  end

  assign mag_o = mag_r;
  assign neg_o = neg_r;

endmodule

// ===== rtl/core/pit_scale.sv =====
// ----------------------------------------------------------------------------
// pit_scale
// Common right shift of three magnitudes below 2^31, then sum of squares.
// ----------------------------------------------------------------------------
module pit_scale (
  input  logic                clk,
  input  logic                en,
  input  pit_pkg::mag_t       mag_i [3],
  input  logic [2:0]          neg_i,
  output pit_pkg::side_t      side_o,
  output pit_pkg::sum_t       sum_o
);

  pit_pkg::mag_t sh_w   [pit_pkg::SHIFT_STAGES+1][3];
  pit_pkg::mag_t sm_nxt [pit_pkg::SHIFT_STAGES][3];
  pit_pkg::mag_t sm_r   [pit_pkg::SHIFT_STAGES][3];
  logic [2:0]    neg_r  [pit_pkg::LAT_SCALE];
  logic          nz_r   [pit_pkg::LAT_SCALE];
  logic [pit_pkg::SQ_W-1:0] sq_r [3];
  pit_pkg::red_t msq_r  [3];
  pit_pkg::red_t msum_r [3];
  pit_pkg::sum_t sum_r;

  always_comb begin
    pit_pkg::mag_t any_w;
    pit_pkg::mag_t cur [3];
    for (int i = 0; i < 3; i++) sh_w[0][i] = mag_i[i];
    for (int g = 0; g < pit_pkg::SHIFT_STAGES; g++) begin
      for (int i = 0; i < 3; i++) sh_w[g+1][i] = sm_r[g][i];
    end
    for (int g = 0; g < pit_pkg::SHIFT_STAGES; g++) begin
      for (int i = 0; i < 3; i++) cur[i] = sh_w[g][i];
      for (int k = 0; k < pit_pkg::STEPS_PER_STAGE; k++) begin
        any_w = cur[0] | cur[1] | cur[2];
        if (|(any_w >> (pit_pkg::RED_W +
              pit_pkg::SHIFT_AMT[g*pit_pkg::STEPS_PER_STAGE+k] - 1))) begin
          for (int i = 0; i < 3; i++)
            cur[i] = cur[i] >> pit_pkg::SHIFT_AMT[g*pit_pkg::STEPS_PER_STAGE+k];
        end
      end
      for (int i = 0; i < 3; i++) sm_nxt[g][i] = cur[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sm_r     <= sm_nxt;
      neg_r[0] <= neg_i;
      nz_r[0]  <= |(mag_i[0] | mag_i[1] | mag_i[2]);
      for (int g = 1; g < pit_pkg::LAT_SCALE; g++) begin
        neg_r[g] <= neg_r[g-1];
        nz_r[g]  <= nz_r[g-1];
      end
      for (int i = 0; i < 3; i++) begin
        msq_r[i]  <= sm_r[pit_pkg::SHIFT_STAGES-1][i][pit_pkg::RED_W-1:0];
        sq_r[i]   <= sm_r[pit_pkg::SHIFT_STAGES-1][i][pit_pkg::RED_W-1:0]
                   * sm_r[pit_pkg::SHIFT_STAGES-1][i][pit_pkg::RED_W-1:0];
        msum_r[i] <= msq_r[i];
      end
      sum_r <= pit_pkg::SUM_W'(sq_r[0]) + pit_pkg::SUM_W'(sq_r[1])
             + pit_pkg::SUM_W'(sq_r[2]);
    end
  end

  always_comb begin
    side_o.neg = neg_r[pit_pkg::LAT_SCALE-1];
    side_o.nz  = nz_r[pit_pkg::LAT_SCALE-1];
    for (int i = 0; i < 3; i++) side_o.m[i] = msum_r[i];
  end
  assign sum_o = sum_r;

endmodule

// ===== rtl/core/pit_isqrt.sv =====
// ----------------------------------------------------------------------------
// pit_isqrt
// Floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module pit_isqrt (
  input  logic           clk,
  input  logic           en,
  input  pit_pkg::sum_t  rad_i,
  output pit_pkg::norm_t root_o
);

  logic [pit_pkg::REM_W-1:0] rem_w  [pit_pkg::SQRT_STAGES+1];
  pit_pkg::norm_t            root_w [pit_pkg::SQRT_STAGES+1];
  pit_pkg::sum_t             rad_w  [pit_pkg::SQRT_STAGES+1];
  logic [pit_pkg::REM_W-1:0] rem_nxt  [pit_pkg::SQRT_STAGES];
  pit_pkg::norm_t            root_nxt [pit_pkg::SQRT_STAGES];
  pit_pkg::sum_t             rad_nxt  [pit_pkg::SQRT_STAGES];
  logic [pit_pkg::REM_W-1:0] rem_r  [pit_pkg::SQRT_STAGES];
  pit_pkg::norm_t            root_r [pit_pkg::SQRT_STAGES];
  pit_pkg::sum_t             rad_r  [pit_pkg::SQRT_STAGES];

  always_comb begin
    logic [pit_pkg::REM_W-1:0] rem_t;
    logic [pit_pkg::REM_W-1:0] trial;
    rem_w[0]  = '0;
    root_w[0] = '0;
    rad_w[0]  = rad_i;
    for (int k = 0; k < pit_pkg::SQRT_STAGES; k++) begin
      rem_w[k+1]  = rem_r[k];
      root_w[k+1] = root_r[k];
      rad_w[k+1]  = rad_r[k];
    end
    for (int k = 0; k < pit_pkg::SQRT_STAGES; k++) begin
      rem_t = {rem_w[k][pit_pkg::REM_W-3:0], rad_w[k][pit_pkg::SUM_W-1 -: 2]};
      trial = pit_pkg::REM_W'({root_w[k], 2'b01});
      if (rem_t >= trial) begin
        rem_nxt[k]  = rem_t - trial;
        root_nxt[k] = {root_w[k][pit_pkg::NORM_W-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = rem_t;
        root_nxt[k] = {root_w[k][pit_pkg::NORM_W-2:0], 1'b0};
      end
      rad_nxt[k] = rad_w[k] << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      rad_r  <= rad_nxt;
    end
  end

  assign root_o = root_r[pit_pkg::SQRT_STAGES-1];

endmodule

// ===== rtl/core/pit_udiv.sv =====
// ----------------------------------------------------------------------------
// pit_udiv
// Unit component: floor(m * 2^FRAC_W / norm), one quotient bit per stage,
// sign applied in a last stage.
// ----------------------------------------------------------------------------
module pit_udiv (
  input  logic           clk,
  input  logic           en,
  input  pit_pkg::red_t  m_i,
  input  logic           neg_i,
  input  pit_pkg::norm_t norm_i,
  output pit_pkg::unit_t unit_o
);

  localparam int R_W = pit_pkg::NORM_W + 1;

  logic [R_W-1:0]           rsh_w [pit_pkg::DIV_STEPS];
  logic [pit_pkg::Q_W-1:0]  q_w   [pit_pkg::DIV_STEPS];
  pit_pkg::norm_t           d_w   [pit_pkg::DIV_STEPS];
  logic                     n_w   [pit_pkg::DIV_STEPS];
  pit_pkg::norm_t           r_nxt [pit_pkg::DIV_STEPS];
  logic [pit_pkg::Q_W-1:0]  q_nxt [pit_pkg::DIV_STEPS];
  pit_pkg::norm_t           r_r   [pit_pkg::DIV_STEPS];
  logic [pit_pkg::Q_W-1:0]  q_r   [pit_pkg::DIV_STEPS];
  pit_pkg::norm_t           d_r   [pit_pkg::DIV_STEPS];
  logic                     n_r   [pit_pkg::DIV_STEPS];
  pit_pkg::unit_t           unit_r;
  logic [pit_pkg::UNIT_W-1:0] qx_w;

  always_comb begin
    logic bit_w;
    rsh_w[0] = R_W'(m_i);
    q_w[0]   = '0;
    d_w[0]   = norm_i;
    n_w[0]   = neg_i;
    for (int k = 1; k < pit_pkg::DIV_STEPS; k++) begin
      rsh_w[k] = {r_r[k-1], 1'b0};
      q_w[k]   = q_r[k-1];
      d_w[k]   = d_r[k-1];
      n_w[k]   = n_r[k-1];
    end
    for (int k = 0; k < pit_pkg::DIV_STEPS; k++) begin
      bit_w    = rsh_w[k] >= R_W'(d_w[k]);
      r_nxt[k] = bit_w ? pit_pkg::NORM_W'(rsh_w[k] - R_W'(d_w[k]))
                       : pit_pkg::NORM_W'(rsh_w[k]);
      q_nxt[k] = {q_w[k][pit_pkg::Q_W-2:0], bit_w};
    end
  end

  assign qx_w = {1'b0, q_r[pit_pkg::DIV_STEPS-1]};

  always_ff @(posedge clk) begin
    if (en) begin
      r_r    <= r_nxt;
      q_r    <= q_nxt;
      d_r    <= d_w;
      n_r    <= n_w;
      unit_r <= n_r[pit_pkg::DIV_STEPS-1] ? -qx_w : qx_w;
    end
  end

  assign unit_o = unit_r;

endmodule

// ===== rtl/core/point_in_triangle_test.sv =====
// ----------------------------------------------------------------------------
// point_in_triangle_test
// Same-side point-in-triangle test on Q16.16 vertices, fully pipelined.
//
//   channel  direction  signals
//   in       sink       in_valid / in_ready, vertices A B C and probe
//   out      source     out_valid / out_ready, out_inside_res
//   cfg      sink       cfg_wr_en, cfg_wr_data (tolerance, unsigned Q1.30)
//
// One beat in per cycle while the output is not stalled; the depth is set by
// the 32-step square root and the 31-step divide plus the product stages.
// Synchronous active-low reset clears the valid chain; tolerance goes to 1074.
// When out_valid is high and out_ready low, the whole pipeline holds.
// ----------------------------------------------------------------------------
`include "point_in_triangle_test_macros.svh"

module point_in_triangle_test (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [pit_pkg::TOL_W-1:0]   cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  pit_pkg::coord_t             in_vert_a_x,
  input  pit_pkg::coord_t             in_vert_a_y,
  input  pit_pkg::coord_t             in_vert_a_z,
  input  pit_pkg::coord_t             in_vert_b_x,
  input  pit_pkg::coord_t             in_vert_b_y,
  input  pit_pkg::coord_t             in_vert_b_z,
  input  pit_pkg::coord_t             in_vert_c_x,
  input  pit_pkg::coord_t             in_vert_c_y,
  input  pit_pkg::coord_t             in_vert_c_z,
  input  pit_pkg::coord_t             in_probe_x,
  input  pit_pkg::coord_t             in_probe_y,
  input  pit_pkg::coord_t             in_probe_z,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_inside_res
);

  logic                              adv;
  logic [pit_pkg::LAT_TOTAL-1:0]     vld_r;
  logic [pit_pkg::TOL_W-1:0]         tol_r;
  pit_pkg::coord_t                   vert_w [3][3];
  pit_pkg::coord_t                   probe_w [3];
  pit_pkg::mag_t                     mag_w [3][3];
  logic [2:0]                        neg_w [3];
  pit_pkg::side_t                    side_w [3];
  pit_pkg::sum_t                     sum_w [3];
  pit_pkg::norm_t                    root_w [3];
  pit_pkg::side_t                    side_d_r [3][pit_pkg::SQRT_STAGES];
  logic                              nz_d_r [3][pit_pkg::LAT_DIV];
  pit_pkg::unit_t                    unit_w [3][3];
  logic signed [pit_pkg::UDIF_W-1:0] dif_r [2][3];
  logic                              nzall_r;
  logic                              res_r;
  logic                              res_nxt;

  assign adv      = !vld_r[pit_pkg::LAT_TOTAL-1] || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      tol_r <= pit_pkg::TOL_W'(pit_pkg::TOL_RESET);
    end else begin
      if (adv) vld_r <= {vld_r[pit_pkg::LAT_TOTAL-2:0], in_valid};
      if (cfg_wr_en) tol_r <= cfg_wr_data;
    end
  end

  always_comb begin
    vert_w[0] = '{in_vert_a_x, in_vert_a_y, in_vert_a_z};
    vert_w[1] = '{in_vert_b_x, in_vert_b_y, in_vert_b_z};
    vert_w[2] = '{in_vert_c_x, in_vert_c_y, in_vert_c_z};
    probe_w   = '{in_probe_x, in_probe_y, in_probe_z};
  end

  for (genvar e = 0; e < 3; e++) begin : g_edge
    pit_cross u_cross (
      .clk   (clk),
      .en    (adv),
      .s_i   (vert_w[e]),
      .e_i   (vert_w[(e+1)%3]),
      .p_i   (probe_w),
      .mag_o (mag_w[e]),
      .neg_o (neg_w[e])
    );

    pit_scale u_scale (
      .clk    (clk),
      .en     (adv),
      .mag_i  (mag_w[e]),
      .neg_i  (neg_w[e]),
      .side_o (side_w[e]),
      .sum_o  (sum_w[e])
    );

    pit_isqrt u_isqrt (
      .clk    (clk),
      .en     (adv),
      .rad_i  (sum_w[e]),
      .root_o (root_w[e])
    );

    for (genvar c = 0; c < 3; c++) begin : g_comp
      pit_udiv u_udiv (
        .clk    (clk),
        .en     (adv),
        .m_i    (side_d_r[e][pit_pkg::SQRT_STAGES-1].m[c]),
        .neg_i  (side_d_r[e][pit_pkg::SQRT_STAGES-1].neg[c]),
        .norm_i (root_w[e]),
        .unit_o (unit_w[e][c])
      );
    end
  end

  // sideband delay across the square root and the divide
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int e = 0; e < 3; e++) begin
        side_d_r[e][0] <= side_w[e];
        for (int k = 1; k < pit_pkg::SQRT_STAGES; k++) side_d_r[e][k] <= side_d_r[e][k-1];
        nz_d_r[e][0] <= side_d_r[e][pit_pkg::SQRT_STAGES-1].nz;
        for (int k = 1; k < pit_pkg::LAT_DIV; k++) nz_d_r[e][k] <= nz_d_r[e][k-1];
      end
    end
  end

  always_comb begin
    logic [pit_pkg::UDIF_W-1:0] ad;
    res_nxt = nzall_r;
    for (int j = 0; j < 2; j++) begin
      for (int c = 0; c < 3; c++) begin
        ad = dif_r[j][c][pit_pkg::UDIF_W-1] ? pit_pkg::UDIF_W'(-dif_r[j][c])
                                            : pit_pkg::UDIF_W'(dif_r[j][c]);
        if (ad >= pit_pkg::UDIF_W'(tol_r)) res_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 2; j++) begin
        for (int c = 0; c < 3; c++) begin
          dif_r[j][c] <= {unit_w[0][c][pit_pkg::UNIT_W-1], unit_w[0][c]}
                       - {unit_w[j+1][c][pit_pkg::UNIT_W-1], unit_w[j+1][c]};
        end
      end
      nzall_r <= nz_d_r[0][pit_pkg::LAT_DIV-1] && nz_d_r[1][pit_pkg::LAT_DIV-1]
              && nz_d_r[2][pit_pkg::LAT_DIV-1];
      res_r   <= res_nxt;
    end
  end

  assign out_valid      = vld_r[pit_pkg::LAT_TOTAL-1];
  assign out_inside_res = res_r;

  `PIT_ASSERT_RST(a_rst_clears_out, !rst_n |=> !out_valid, "output valid after reset")
  `PIT_ASSERT(a_stall_freezes, !adv |=> $stable(vld_r), "valid chain moved during stall")
  `PIT_ASSERT(a_accept_enters, in_valid && in_ready |=> vld_r[0], "accepted beat not tracked")

endmodule
